// ===== src/por_pkg.sv =====
// Shared types and constants for the pattern occurrence remover.
`timescale 1ns / 1ps
package por_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int PAT_IDX_W       = 4;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int LEN_REG_W       = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH_HEAD,
        ST_FLUSH_TAIL
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_STEP_IN,
        OP_LATCH,
        OP_FLUSH_BYTE,
        OP_STEP_HELD,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        logic slot_free;
        logic partial_nz;
        logic extend;
        logic flush_done;
        logic last_held;
    } dp_status_t;

endpackage

// ===== src/por_controller.sv =====
// Control state machine: sequences input steps, flushes and the closing word.
`timescale 1ns / 1ps
module por_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_end_of_input,
    output logic                s_ready,
    input  por_pkg::dp_status_t status,
    output por_pkg::dp_op_t     op
);
    import por_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_ready = status.slot_free;
                if (s_valid && status.slot_free) begin
                    if (status.partial_nz && !status.extend) begin
                        op         = OP_LATCH;
                        state_next = ST_FLUSH_HEAD;
                    end else begin
                        op = OP_STEP_IN;
                        if (s_end_of_input) begin
                            state_next = ST_FLUSH_TAIL;
                        end
                    end
                end
            end
            ST_FLUSH_HEAD: begin
                if (status.slot_free) begin
                    if (!status.flush_done) begin
                        op = OP_FLUSH_BYTE;
                    end else begin
                        op         = OP_STEP_HELD;
                        state_next = status.last_held ? ST_FLUSH_TAIL : ST_RUN;
                    end
                end
            end
            ST_FLUSH_TAIL: begin
                if (status.slot_free) begin
                    if (!status.flush_done) begin
                        op = OP_FLUSH_BYTE;
                    end else begin
                        op         = OP_FINAL;
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

// ===== src/por_datapath.sv =====
// Datapath: pattern registers, match state, removal count and output register.
`timescale 1ns / 1ps
module por_datapath #(
    parameter int MAX_PATTERN = por_pkg::MAX_PATTERN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [por_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [por_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic [por_pkg::BYTE_W-1:0]       s_text_byte,
    input  logic                             s_end_of_input,
    input  logic                             m_ready,
    input  por_pkg::dp_op_t                  op,
    output por_pkg::dp_status_t              status,
    output logic                             m_valid,
    output logic [por_pkg::BYTE_W-1:0]       m_kept_byte,
    output logic                             m_byte_present,
    output logic [por_pkg::COUNT_W-1:0]      m_removed_count,
    output logic                             m_final_item
);
    import por_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LEN_REG_W-1:0]  pattern_length_reg;
    logic [LW-1:0]         partial_reg, partial_next;
    logic [LW-1:0]         k_reg, k_next;
    logic [COUNT_W-1:0]    total_reg, total_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                  out_present_reg, out_present_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_final_reg, out_final_next;

    logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes;
    logic [LW-1:0]         eff_len;
    logic [PAT_IDX_W-1:0]  part_idx;
    logic [PAT_IDX_W-1:0]  k_idx;
    logic [BYTE_W-1:0]     proc_byte;
    logic [LW-1:0]         proc_partial;
    logic [LW-1:0]         partial_inc;
    logic [COUNT_W-1:0]    total_inc;
    logic                  load;

    assign pat_bytes = {pattern_high_reg, pattern_low_reg};
    assign part_idx  = PAT_IDX_W'(partial_reg);
    assign k_idx     = PAT_IDX_W'(k_reg);

    always_comb begin
        if (pattern_length_reg == '0) begin
            eff_len = LW'(1);
        end else if (pattern_length_reg > LEN_REG_W'(MAX_PATTERN)) begin
            eff_len = LW'(MAX_PATTERN);
        end else begin
            eff_len = LW'(pattern_length_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_REG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wr_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wr_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wr_data[LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign status.slot_free  = !out_valid_reg || m_ready;
    assign status.partial_nz = (partial_reg != '0);
    assign status.extend     = (partial_reg != '0) && (partial_reg < eff_len)
                               && (s_text_byte == pat_bytes[part_idx]);
    assign status.flush_done = (k_reg == partial_reg);
    assign status.last_held  = last_reg;

    assign proc_byte    = (op == OP_STEP_HELD) ? byte_reg : s_text_byte;
    assign proc_partial = (op == OP_STEP_HELD) ? '0 : partial_reg;
    assign partial_inc  = proc_partial + LW'(1);
    assign total_inc    = (total_reg == COUNT_MAX) ? total_reg : total_reg + COUNT_W'(1);

    always_comb begin
        partial_next     = partial_reg;
        k_next           = k_reg;
        total_next       = total_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        load             = 1'b0;
        out_byte_next    = out_byte_reg;
        out_present_next = out_present_reg;
        out_count_next   = out_count_reg;
        out_final_next   = out_final_reg;
        case (op)
            OP_STEP_IN, OP_STEP_HELD: begin
                k_next = '0;
                if (proc_partial != '0) begin
                    if (partial_inc == eff_len) begin
                        total_next   = total_inc;
                        partial_next = '0;
                    end else begin
                        partial_next = partial_inc;
                    end
                end else if (proc_byte == pat_bytes[0]) begin
                    if (eff_len == LW'(1)) begin
                        total_next   = total_inc;
                        partial_next = '0;
                    end else begin
                        partial_next = LW'(1);
                    end
                end else begin
                    partial_next     = '0;
                    load             = 1'b1;
                    out_byte_next    = proc_byte;
                    out_present_next = 1'b1;
                    out_count_next   = total_reg;
                    out_final_next   = 1'b0;
                end
            end
            OP_LATCH: begin
                byte_next = s_text_byte;
                last_next = s_end_of_input;
                k_next    = '0;
            end
            OP_FLUSH_BYTE: begin
                load             = 1'b1;
                out_byte_next    = pat_bytes[k_idx];
                out_present_next = 1'b1;
                out_count_next   = total_reg;
                out_final_next   = 1'b0;
                k_next           = k_reg + LW'(1);
            end
            OP_FINAL: begin
                load             = 1'b1;
                out_byte_next    = '0;
                out_present_next = 1'b0;
                out_count_next   = total_reg;
                out_final_next   = 1'b1;
                partial_next     = '0;
                total_next       = '0;
                k_next           = '0;
            end
            default: ;
        endcase
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg   <= '0;
            k_reg         <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            partial_reg   <= partial_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg        <= byte_next;
        last_reg        <= last_next;
        out_byte_reg    <= out_byte_next;
        out_present_reg <= out_present_next;
        out_count_reg   <= out_count_next;
        out_final_reg   <= out_final_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_kept_byte     = out_byte_reg;
    assign m_byte_present  = out_present_reg;
    assign m_removed_count = out_count_reg;
    assign m_final_item    = out_final_reg;

endmodule

// ===== src/pattern_occurrence_remover_core.sv =====
// Top level: pattern occurrence remover, controller plus datapath.
// A kept byte is written to the registered output word when its input word is processed.
// Throughput: one input word per cycle while no partial match fails and the output is not stalled.
// A failed partial match of k bytes holds the input while the k prefix bytes are replayed.
// At end of text the p pending prefix bytes are flushed, then the closing word with the count is sent.
// Reset (synchronous, aresetn low) clears match state, count, output valid and pattern bytes, and sets length 1.
`timescale 1ns / 1ps
module pattern_occurrence_remover_core #(
    parameter int MAX_PATTERN = por_pkg::MAX_PATTERN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [por_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [por_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [por_pkg::BYTE_W-1:0]     s_text_byte,
    input  logic                           s_end_of_input,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [por_pkg::BYTE_W-1:0]     m_kept_byte,
    output logic                           m_byte_present,
    output logic [por_pkg::COUNT_W-1:0]    m_removed_count,
    output logic                           m_final_item
);
    import por_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    por_controller u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_end_of_input (s_end_of_input),
        .s_ready        (s_ready),
        .status         (status),
        .op             (op)
    );

    por_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_text_byte     (s_text_byte),
        .s_end_of_input  (s_end_of_input),
        .m_ready         (m_ready),
        .op              (op),
        .status          (status),
        .m_valid         (m_valid),
        .m_kept_byte     (m_kept_byte),
        .m_byte_present  (m_byte_present),
        .m_removed_count (m_removed_count),
        .m_final_item    (m_final_item)
    );

endmodule

// ===== src/por_checker.sv =====
// Port-level checks for the pattern occurrence remover, bound to the top level.
`timescale 1ns / 1ps
module por_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [por_pkg::BYTE_W-1:0]  m_kept_byte,
    input logic                        m_byte_present,
    input logic [por_pkg::COUNT_W-1:0] m_removed_count,
    input logic                        m_final_item
);
    import por_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kept_byte)
            && $stable(m_removed_count) && $stable(m_final_item))
        else $error("stalled output word changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_present != m_final_item))
        else $error("output word is neither a kept byte nor the closing word");

    a_final_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_final_item |-> (m_kept_byte == '0))
        else $error("closing word carries a byte value");

endmodule

bind pattern_occurrence_remover_core por_checker u_por_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_kept_byte     (m_kept_byte),
    .m_byte_present  (m_byte_present),
    .m_removed_count (m_removed_count),
    .m_final_item    (m_final_item)
);

// ===== tb/testbench.sv =====
// Testbench for pattern_occurrence_remover_core: streams text words and checks each output word.
`timescale 1ns / 1ps
module testbench;
    import por_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [BYTE_W-1:0]  kept_byte;
        logic               byte_present;
        logic [COUNT_W-1:0] removed_count;
        logic               final_item;
    } out_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_reg_t              cfg_index = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_text_byte = '0;
    logic                  s_end_of_input = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BYTE_W-1:0]     m_kept_byte;
    logic                  m_byte_present;
    logic [COUNT_W-1:0]    m_removed_count;
    logic                  m_final_item;

    logic [CFG_DATA_W-1:0] model_pat_low = '0;
    logic [CFG_DATA_W-1:0] model_pat_high = '0;
    logic [LEN_REG_W-1:0]  model_pat_len = 5'd1;
    int unsigned           match_depth = 0;
    logic [COUNT_W-1:0]    removed_total = '0;
    out_word_t             expected_words[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_hold_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned words_checked = 0;
    int unsigned texts_closed = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    pattern_occurrence_remover_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kept_byte     (m_kept_byte),
        .m_byte_present  (m_byte_present),
        .m_removed_count (m_removed_count),
        .m_final_item    (m_final_item)
    );

    always #1 aclk = ~aclk;

    function automatic logic [BYTE_W-1:0] pattern_byte(input int unsigned idx);
        int unsigned          i;
        logic [CFG_DATA_W-1:0] half;
        i = idx % PAT_BYTES;
        half = (i < 8) ? model_pat_low : model_pat_high;
        return half[(i % 8) * 8 +: 8];
    endfunction

    function automatic int unsigned active_length();
        int unsigned n;
        n = 32'(model_pat_len);
        if (n == 0) n = 1;
        if (n > MAX_PATTERN_DEF) n = MAX_PATTERN_DEF;
        return n;
    endfunction

    function automatic void queue_word(input logic [BYTE_W-1:0] b, input logic present,
                                       input logic fin);
        out_word_t w;
        w.kept_byte = b;
        w.byte_present = present;
        w.removed_count = removed_total;
        w.final_item = fin;
        expected_words.push_back(w);
    endfunction

    function automatic void count_removal();
        if (removed_total != COUNT_MAX) removed_total++;
    endfunction

    function automatic void replay_prefix();
        for (int unsigned k = 0; k < match_depth && k < PAT_BYTES; k++) begin
            queue_word(pattern_byte(k), 1'b1, 1'b0);
        end
        match_depth = 0;
    endfunction

    function automatic void predict_text_byte(input logic [BYTE_W-1:0] c, input logic last);
        int unsigned len;
        logic        live;
        len = active_length();
        live = 1'b1;
        if (match_depth > 0) begin
            if (match_depth < len && c == pattern_byte(match_depth)) begin
                match_depth++;
                if (match_depth == len) begin
                    count_removal();
                    match_depth = 0;
                end
                live = 1'b0;
            end else begin
                replay_prefix();
            end
        end
        if (live) begin
            if (c == pattern_byte(0)) begin
                if (len == 1) begin
                    count_removal();
                    match_depth = 0;
                end else begin
                    match_depth = 1;
                end
            end else begin
                queue_word(c, 1'b1, 1'b0);
            end
        end
        if (last) begin
            replay_prefix();
            queue_word('0, 1'b0, 1'b1);
            match_depth = 0;
            removed_total = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        out_word_t seen;
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen = {m_kept_byte, m_byte_present, m_removed_count, m_final_item};
                words_checked++;
                if (seen.final_item) texts_closed++;
                if (expected_words.size() == 0) begin
                    $error("unexpected output word: kept_byte %0h present %0b count %0d final %0b",
                           seen.kept_byte, seen.byte_present, seen.removed_count,
                           seen.final_item);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("kept_byte", COUNT_W'(want.kept_byte),
                                COUNT_W'(seen.kept_byte));
                    check_field("byte_present", COUNT_W'(want.byte_present),
                                COUNT_W'(seen.byte_present));
                    check_field("removed_count", want.removed_count, seen.removed_count);
                    check_field("final_item", COUNT_W'(want.final_item),
                                COUNT_W'(seen.final_item));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PATTERN_LOW: begin
                        model_pat_low = cfg_wr_data;
                    end
                    REG_PATTERN_HIGH: begin
                        model_pat_high = cfg_wr_data;
                    end
                    REG_PATTERN_LENGTH: begin
                        model_pat_len = cfg_wr_data[LEN_REG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                bytes_sent++;
                predict_text_byte(s_text_byte, s_end_of_input);
            end
        end
    end

    always @(negedge aclk) begin
        if (rx_hold_left != 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d words still expected", cycle_count,
                 expected_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_text_byte(input logic [BYTE_W-1:0] b, input logic last);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_end_of_input <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_pattern(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                                input logic [CFG_DATA_W-1:0] len);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, len);
    endtask

    task automatic load_random_pattern();
        logic [BYTE_W-1:0]     base;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] len_word;
        logic                  wide;
        base = BYTE_W'($urandom());
        wide = ($urandom_range(4) == 0);
        for (int k = 0; k < 8; k++) begin
            lo[k*8 +: 8] = wide ? BYTE_W'($urandom()) : base + BYTE_W'($urandom_range(1));
            hi[k*8 +: 8] = wide ? BYTE_W'($urandom()) : base + BYTE_W'($urandom_range(1));
        end
        len_word = {$urandom(), $urandom()};
        case ($urandom_range(9))
            7, 8: begin
                len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(5, 16));
            end
            9: begin
                len_word[LEN_REG_W-1:0] = ($urandom_range(1) == 0) ? '0
                                          : LEN_REG_W'($urandom_range(17, 31));
            end
            default: begin
                len_word[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(1, 4));
            end
        endcase
        load_pattern(lo, hi, len_word);
    endtask

    task automatic send_random_text();
        logic [BYTE_W-1:0] text[$];
        int unsigned       len;
        int unsigned       cut;
        len = active_length();
        repeat ($urandom_range(1, (len > 4) ? 3 : 8)) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    for (int unsigned k = 0; k < len; k++) text.push_back(pattern_byte(k));
                end
                4, 5, 6: begin
                    cut = $urandom_range(len);
                    for (int unsigned k = 0; k < cut; k++) text.push_back(pattern_byte(k));
                end
                7, 8: begin
                    text.push_back(pattern_byte($urandom_range(PAT_BYTES - 1)));
                end
                default: begin
                    text.push_back(BYTE_W'($urandom()));
                end
            endcase
        end
        if (text.size() == 0) text.push_back(BYTE_W'($urandom()));
        foreach (text[i]) send_text_byte(text[i], i == text.size() - 1);
    endtask

    task automatic test_reset_pattern();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h00, 1'b1);
        drain();
    endtask

    task automatic test_partial_restart();
        load_pattern(64'h0000_0000_0062_6161, '0, 64'd3);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        send_text_byte(8'h61, 1'b1);
        drain();
    endtask

    task automatic test_config_mid_text();
        load_pattern(64'h0000_0000_0063_6261, '0, 64'd3);
        send_text_byte(8'h61, 1'b0);
        send_text_byte(8'h62, 1'b0);
        drain();
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        send_text_byte(8'h78, 1'b1);
        send_text_byte(8'h61, 1'b0);
        drain();
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0063_627A);
        send_text_byte(8'h71, 1'b1);
        drain();
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        send_text_byte(8'h7A, 1'b0);
        send_text_byte(8'h79, 1'b1);
        drain();
    endtask

    task automatic test_full_length_flush();
        load_pattern(64'hFF01_0203_0405_0600, 64'h80FE_FDFC_FBFA_F9F8, 64'd31);
        for (int unsigned k = 0; k < MAX_PATTERN_DEF - 1; k++) begin
            send_text_byte(pattern_byte(k), 1'b0);
        end
        send_text_byte(8'h7F, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_pattern(64'h0000_0000_0000_6261, '0, 64'd2);
        rx_hold_left = 300;
        repeat (30) send_text_byte(8'h61 + BYTE_W'($urandom_range(2)), 1'b0);
        send_text_byte(8'h63, 1'b1);
        drain();
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned n_bytes);
        int unsigned start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = bytes_sent;
        load_random_pattern();
        while (bytes_sent - start < n_bytes) begin
            if ($urandom_range(2) == 0) begin
                drain();
                load_random_pattern();
            end
            send_random_text();
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_pct = 36;
        rx_idle_pct = 67;
        test_reset_pattern();
        test_partial_restart();
        test_config_mid_text();
        test_full_length_flush();
        test_backpressure();
        test_random_traffic(36, 67, 25);
        test_random_traffic(67, 36, 25);
        test_random_traffic(0, 0, 25);
        drain();
        $display("Covered %0d texts, %0d input bytes and %0d output words checked.",
                 texts_closed, bytes_sent, words_checked);
        $display("Included restarts, mid-text register changes, length clamping and long stalls.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
